### rtl/core/emx_pkg.sv
// emx_pkg: shared types and constants for the ElGamal modexp engine.
// No dependencies.
package emx_pkg;
   localparam int WORD_BITS = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_BITS = 1;

   localparam logic [1:0] OP_PUBKEY  = 2'd0;
   localparam logic [1:0] OP_ENCRYPT = 2'd1;
   localparam logic [1:0] OP_DECRYPT = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MSG_BAD = 2'd1;
   localparam logic [1:0] ST_K_BAD   = 2'd2;

   localparam logic [1:0] REG_MODULUS = 2'd0;
   localparam logic [1:0] REG_GEN     = 2'd1;
   localparam logic [1:0] REG_KEY     = 2'd2;

   // classified job handed from front to back
   typedef struct packed {
      logic [1:0]           kind;     // OP_* code as received, also the unused code
      logic                 run;      // needs exponentiation
      logic [1:0]           status;
      logic [WORD_BITS-1:0] message;
      logic [WORD_BITS-1:0] nonce;
      logic [WORD_BITS-1:0] cipher_first;
      logic [WORD_BITS-1:0] cipher_second;
   } job_type;

   typedef struct packed {
      logic                 start;
      logic [WORD_BITS-1:0] base;
      logic [WORD_BITS-1:0] expo;
   } pow_req_type;
endpackage

### rtl/core/emx_mulmod.sv
// emx_mulmod: iterative modular multiplier, two product bits per cycle (double-and-add).
// Depends on emx_pkg.
module emx_mulmod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [emx_pkg::WORD_BITS-1:0] op_a,
   input  logic [emx_pkg::WORD_BITS-1:0] op_b,
   input  logic [emx_pkg::WORD_BITS-1:0] modulus,
   output logic                          done,
   output logic [emx_pkg::WORD_BITS-1:0] result
);
   localparam int W = emx_pkg::WORD_BITS;
   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  acc_ff, acc_in, a_ff, a_in, b_ff, b_in;
   logic          done_ff, done_in;

   function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) addm = W'(s - {1'b0, m});
      else addm = s[W-1:0];
   endfunction

   always_comb begin
      logic [W-1:0] r;
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      done_in = 1'b0;
      r = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CW'(W);
         acc_in = '0;
         a_in = op_a;
         b_in = op_b;
      end else if (busy_ff) begin
         r = addm(r, r, modulus);
         if (b_ff[W-1]) r = addm(r, a_ff, modulus);
         r = addm(r, r, modulus);
         if (b_ff[W-2]) r = addm(r, a_ff, modulus);
         acc_in = r;
         b_in = b_ff << 2;
         cnt_in = cnt_ff - CW'(2);
         if (cnt_ff == CW'(2)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign done = done_ff;
   assign result = acc_ff;
endmodule

### rtl/core/emx_front.sv
// emx_front: accepts items, checks encryption operands and queues classified jobs.
// Depends on emx_pkg.
module emx_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [1:0]                    opcode,
   input  logic [emx_pkg::WORD_BITS-1:0] message,
   input  logic [emx_pkg::WORD_BITS-1:0] nonce,
   input  logic [emx_pkg::WORD_BITS-1:0] cipher_first,
   input  logic [emx_pkg::WORD_BITS-1:0] cipher_second,
   input  logic [emx_pkg::WORD_BITS-1:0] modulus,
   output logic                          job_valid,
   output emx_pkg::job_type              job,
   input  logic                          job_take
);
   localparam int D = emx_pkg::QUEUE_DEPTH;
   localparam int IB = emx_pkg::QUEUE_IDX_BITS;

   emx_pkg::job_type q_ff [D];
   emx_pkg::job_type cls;
   logic [IB-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [IB:0]   cnt_ff, cnt_in;
   logic          acc;

   always_comb begin
      cls.kind = opcode;
      cls.run = 1'b0;
      cls.status = emx_pkg::ST_OK;
      cls.message = message;
      cls.nonce = nonce;
      cls.cipher_first = cipher_first;
      cls.cipher_second = cipher_second;
      case (opcode)
         emx_pkg::OP_PUBKEY: cls.run = (modulus != '0);
         emx_pkg::OP_ENCRYPT: begin
            if (message >= modulus) cls.status = emx_pkg::ST_MSG_BAD;
            else if (nonce <= 1 || nonce >= modulus) cls.status = emx_pkg::ST_K_BAD;
            else cls.run = 1'b1;
         end
         emx_pkg::OP_DECRYPT: cls.run = (modulus != '0);
         default: cls.run = 1'b0;
      endcase
   end

   assign full = (cnt_ff == (IB+1)'(D));
   assign acc = push && !full;
   assign job_valid = (cnt_ff != '0);
   assign job = q_ff[rp_ff];

   always_comb begin
      wp_in = acc ? wp_ff + 1'b1 : wp_ff;
      rp_in = (job_take && job_valid) ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (IB+1)'(acc) - (IB+1)'(job_take && job_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (acc) q_ff[wp_ff] <= cls;
   end
endmodule

### rtl/core/emx_back.sv
// emx_back: sequences the exponentiations for one job and holds its result.
// Depends on emx_pkg and emx_mulmod.
module emx_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  emx_pkg::job_type              job,
   output logic                          job_take,
   input  logic [emx_pkg::WORD_BITS-1:0] modulus,
   input  logic [emx_pkg::WORD_BITS-1:0] generator,
   input  logic [emx_pkg::WORD_BITS-1:0] private_key,
   output logic                          empty,
   input  logic                          pop,
   output logic [emx_pkg::WORD_BITS-1:0] value_a,
   output logic [emx_pkg::WORD_BITS-1:0] value_b,
   output logic [1:0]                    status
);
   localparam int W = emx_pkg::WORD_BITS;
   localparam int CW = $clog2(W + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RED   = 4'd1;  // start a power, or the final multiply, from the reduced operand
   localparam logic [3:0] S_POW   = 4'd2;  // pick step of square-and-multiply
   localparam logic [3:0] S_MWAIT = 4'd3;  // r*b pending
   localparam logic [3:0] S_SWAIT = 4'd4;  // b*b pending
   localparam logic [3:0] S_NEXT  = 4'd5;  // next exponentiation or final multiply
   localparam logic [3:0] S_FWAIT = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;
   localparam logic [3:0] S_REDW  = 4'd8;

   logic [3:0]   st_ff, st_in;
   logic [2:0]   ph_ff, ph_in;   // phase within the job
   emx_pkg::job_type job_ff, job_in;
   logic [W-1:0] r_ff, r_in, b_ff, b_in, e_ff, e_in, t_ff, t_in;
   logic [CW-1:0] n_ff, n_in;
   logic [W-1:0] oa_ff, oa_in, ob_ff, ob_in;
   logic [1:0]   os_ff, os_in;
   logic         full_ff, full_in;
   logic         ms, md;
   logic [W-1:0] ma, mb, mr;
   logic [W-1:0] r1;

   // operand reduction mod p: restoring remainder, one bit per cycle
   logic [W-1:0] rd_x_ff, rd_x_in;
   logic [W:0]   rd_r_ff, rd_r_in;

   emx_mulmod u_mul (
      .clock(clock), .reset(reset), .start(ms), .op_a(ma), .op_b(mb),
      .modulus(modulus), .done(md), .result(mr)
   );

   assign r1 = (modulus == W'(1)) ? '0 : W'(1);

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; job_in = job_ff;
      r_in = r_ff; b_in = b_ff; e_in = e_ff; t_in = t_ff; n_in = n_ff;
      oa_in = oa_ff; ob_in = ob_ff; os_in = os_ff; full_in = full_ff;
      rd_x_in = rd_x_ff; rd_r_in = rd_r_ff;
      ms = 1'b0; ma = r_ff; mb = b_ff;
      job_take = 1'b0;
      if (full_ff && pop) full_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               job_in = job;
               if (!job.run) begin
                  oa_in = '0; ob_in = '0; os_in = job.status;
                  st_in = S_OUT;
               end else begin
                  // phase 0: reduce the base for the first power
                  ph_in = 3'd0;
                  rd_x_in = (job.kind == emx_pkg::OP_DECRYPT) ? job.cipher_first : generator;
                  rd_r_in = '0; n_in = CW'(W);
                  st_in = S_REDW;
               end
            end
         end
         S_REDW: begin
            // restoring remainder, one bit per cycle
            logic [W:0] tr;
            tr = {rd_r_ff[W-1:0], rd_x_ff[W-1]};
            if (tr >= {1'b0, modulus}) tr = tr - {1'b0, modulus};
            rd_r_in = tr;
            rd_x_in = rd_x_ff << 1;
            n_in = n_ff - CW'(1);
            if (n_ff == CW'(1)) st_in = S_RED;
         end
         S_RED: begin
            // start power: base = reduced value; in phase 5 the final multiply instead
            if (ph_ff == 3'd5) begin
               ma = t_ff; mb = rd_r_ff[W-1:0]; ms = 1'b1;
               st_in = S_FWAIT;
            end else begin
               b_in = rd_r_ff[W-1:0];
               r_in = r1;
               case (ph_ff)
                  3'd0: e_in = (job_ff.kind == emx_pkg::OP_ENCRYPT) ? job_ff.nonce : private_key;
                  default: e_in = e_ff;
               endcase
               st_in = S_POW;
            end
         end
         S_POW: begin
            if (e_ff == '0) st_in = S_NEXT;
            else if (e_ff[0]) begin
               ma = r_ff; mb = b_ff; ms = 1'b1; st_in = S_MWAIT;
            end else begin
               ma = b_ff; mb = b_ff; ms = 1'b1; st_in = S_SWAIT;
            end
         end
         S_MWAIT: if (md) begin
            r_in = mr; ma = b_ff; mb = b_ff; ms = 1'b1; st_in = S_SWAIT;
         end
         S_SWAIT: if (md) begin
            b_in = mr; e_in = e_ff >> 1; st_in = S_POW;
         end
         S_NEXT: begin
            case (job_ff.kind)
               emx_pkg::OP_PUBKEY: begin
                  oa_in = r_ff; ob_in = '0; os_in = emx_pkg::ST_OK; st_in = S_OUT;
               end
               emx_pkg::OP_ENCRYPT: begin
                  if (ph_ff == 3'd0) begin
                     // c1 = g^k done; now y = g^x
                     t_in = r_ff; ph_in = 3'd1;
                     rd_x_in = generator; rd_r_in = '0; n_in = CW'(W);
                     e_in = private_key; st_in = S_REDW;
                  end else if (ph_ff == 3'd1) begin
                     // y^k
                     ph_in = 3'd2; b_in = r_ff; r_in = r1; e_in = job_ff.nonce;
                     st_in = S_POW;
                  end else begin
                     ma = job_ff.message; mb = r_ff; ms = 1'b1;
                     ph_in = 3'd3; st_in = S_FWAIT;
                  end
               end
               default: begin
                  if (ph_ff == 3'd0) begin
                     // s = c1^x; now s^(p-2)
                     ph_in = 3'd1; b_in = r_ff; r_in = r1; e_in = modulus - W'(2);
                     st_in = S_POW;
                  end else begin
                     t_in = r_ff; ph_in = 3'd5;
                     rd_x_in = job_ff.cipher_second; rd_r_in = '0; n_in = CW'(W);
                     st_in = S_REDW;
                  end
               end
            endcase
         end
         S_FWAIT: if (md) begin
            os_in = emx_pkg::ST_OK;
            if (job_ff.kind == emx_pkg::OP_ENCRYPT) begin
               oa_in = t_ff; ob_in = mr;
            end else begin
               oa_in = mr; ob_in = '0;
            end
            st_in = S_OUT;
         end
         S_OUT: if (!full_ff || pop) begin
            full_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      if (st_ff == S_RED && ph_ff == 3'd1 && job_ff.kind == emx_pkg::OP_ENCRYPT)
         e_in = private_key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ph_ff <= '0;
         full_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         st_ff <= st_in;
         ph_ff <= ph_in;
         full_ff <= full_in;
         n_ff <= n_in;
      end
      job_ff <= job_in;
      r_ff <= r_in; b_ff <= b_in; e_ff <= e_in; t_ff <= t_in;
      rd_x_ff <= rd_x_in; rd_r_ff <= rd_r_in;
      if (st_ff == S_OUT && (!full_ff || pop)) begin
         value_a <= oa_ff; value_b <= ob_ff; status <= os_ff;
      end
      oa_ff <= oa_in; ob_ff <= ob_in; os_ff <= os_in;
   end

   assign empty = !full_ff;
endmodule

### rtl/core/elgamal_modexp_engine_core.sv
// ElGamal engine top level: configuration registers, front classifier, back sequencer.
// Depends on emx_pkg, emx_front, emx_back, emx_mulmod.
// Rate: one item at a time in the back end. Each modular multiply runs in the serial
// multiplier (two bits per cycle); an exponentiation is up to 64 multiplies, and each
// operand is first reduced mod p. Encrypt runs three exponentiations, decrypt runs two.
// Rejected or unused-opcode items skip the exponentiations. Two items queue up between
// the input and the sequencer; one result waits in the output register.
module elgamal_modexp_engine_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_opcode,
   input  logic [emx_pkg::WORD_BITS-1:0] req_message,
   input  logic [emx_pkg::WORD_BITS-1:0] req_nonce,
   input  logic [emx_pkg::WORD_BITS-1:0] req_cipher_first,
   input  logic [emx_pkg::WORD_BITS-1:0] req_cipher_second,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [emx_pkg::WORD_BITS-1:0] rsp_value_a,
   output logic [emx_pkg::WORD_BITS-1:0] rsp_value_b,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [3:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   logic [31:0] mod_ff, gen_ff, key_ff;
   logic        job_valid, job_take;
   emx_pkg::job_type job;
   logic [1:0]  ridx;

   assign csr_pready = 1'b1;
   assign ridx = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= 32'd23;
         gen_ff <= 32'd5;
         key_ff <= 32'd6;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00) begin
         case (ridx)
            emx_pkg::REG_MODULUS: mod_ff <= csr_pwdata;
            emx_pkg::REG_GEN:     gen_ff <= csr_pwdata;
            emx_pkg::REG_KEY:     key_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         emx_pkg::REG_MODULUS: csr_prdata = mod_ff;
         emx_pkg::REG_GEN:     csr_prdata = gen_ff;
         emx_pkg::REG_KEY:     csr_prdata = key_ff;
         default:              csr_prdata = '0;
      endcase
   end

   emx_front u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .opcode(req_opcode), .message(req_message), .nonce(req_nonce),
      .cipher_first(req_cipher_first), .cipher_second(req_cipher_second),
      .modulus(mod_ff), .job_valid(job_valid), .job(job), .job_take(job_take)
   );

   emx_back u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job(job), .job_take(job_take),
      .modulus(mod_ff), .generator(gen_ff), .private_key(key_ff),
      .empty(rsp_empty), .pop(rsp_pop), .value_a(rsp_value_a), .value_b(rsp_value_b),
      .status(rsp_status)
   );
endmodule

### tb/elgamal_modexp_checker.sv
// Checker for the ElGamal modexp engine: follows register writes on the CSR port,
// predicts each result from the accepted items and compares the popped results.
// Depends on emx_pkg.
module elgamal_modexp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_message,
   input  logic [31:0] req_nonce,
   input  logic [31:0] req_cipher_first,
   input  logic [31:0] req_cipher_second,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [31:0] rsp_value_a,
   input  logic [31:0] rsp_value_b,
   input  logic [1:0]  rsp_status,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] value_a;
      logic [31:0] value_b;
      logic [1:0]  status;
   } answer_type;

   answer_type  answers[$];
   logic [31:0] prime_p, gen_g, key_x;

   function automatic logic [31:0] mul_reduce(logic [31:0] a, logic [31:0] b,
                                              logic [31:0] m);
      logic [63:0] prod;
      prod = {32'd0, a} * {32'd0, b};
      return (m == 0) ? 32'd0 : 32'(prod % {32'd0, m});
   endfunction

   function automatic logic [31:0] power(logic [31:0] b, logic [31:0] e, logic [31:0] m);
      logic [31:0] acc;
      if (m == 0) return 32'd0;
      acc = 32'd1 % m;
      b = b % m;
      for (int i = 0; i < 32; i++) begin
         if (e[i]) acc = mul_reduce(acc, b, m);
         b = mul_reduce(b, b, m);
      end
      return acc;
   endfunction

   function automatic answer_type compute_answer(logic [1:0] op, logic [31:0] m,
                                                 logic [31:0] k, logic [31:0] c1,
                                                 logic [31:0] c2);
      answer_type  r;
      logic [31:0] pub, share;
      r = '0;
      r.status = emx_pkg::ST_OK;
      if (op == emx_pkg::OP_PUBKEY) begin
         r.value_a = power(gen_g, key_x, prime_p);
      end else if (op == emx_pkg::OP_ENCRYPT) begin
         if (m >= prime_p) begin
            r.status = emx_pkg::ST_MSG_BAD;
         end else if (k <= 1 || k >= prime_p) begin
            r.status = emx_pkg::ST_K_BAD;
         end else begin
            pub = power(gen_g, key_x, prime_p);
            r.value_a = power(gen_g, k, prime_p);
            r.value_b = mul_reduce(m, power(pub, k, prime_p), prime_p);
         end
      end else if (op == emx_pkg::OP_DECRYPT && prime_p != 0) begin
         share = power(c1, key_x, prime_p);
         r.value_a = mul_reduce(c2 % prime_p, power(share, prime_p - 32'd2, prime_p),
                                prime_p);
      end
      return r;
   endfunction

   assign pending = answers.size();

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         prime_p <= 32'd23;
         gen_g <= 32'd5;
         key_x <= 32'd6;
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               emx_pkg::REG_MODULUS: prime_p <= csr_pwdata;
               emx_pkg::REG_GEN:     gen_g <= csr_pwdata;
               emx_pkg::REG_KEY:     key_x <= csr_pwdata;
               default: ;
            endcase
         end
         if (req_push && !req_full)
            answers.push_back(compute_answer(req_opcode, req_message, req_nonce,
                                             req_cipher_first, req_cipher_second));
         if (rsp_pop && !rsp_empty) begin
            if (answers.size() == 0) begin
               if (fail_count < 10) $display("%t: result with none expected", $realtime);
               fail_count <= fail_count + 1;
            end else begin
               want = answers.pop_front();
               if (want !== {rsp_value_a, rsp_value_b, rsp_status}) begin
                  if (fail_count < 10)
                     $display("%t: mismatch exp a=%h b=%h st=%0d got a=%h b=%h st=%0d",
                              $realtime, want.value_a, want.value_b, want.status,
                              rsp_value_a, rsp_value_b, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### tb/tb_elgamal_modexp_engine_core.sv
// Testbench top for elgamal_modexp_engine_core: clock, reset, CSR phases and item
// stimulus with random idling; verdict from elgamal_modexp_checker. Depends on emx_pkg.
module tb_elgamal_modexp_engine_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0, req_full;
   logic [1:0]  req_opcode = '0;
   logic [31:0] req_message = '0, req_nonce = '0;
   logic [31:0] req_cipher_first = '0, req_cipher_second = '0;
   logic        rsp_empty, rsp_pop = 1'b0;
   logic [31:0] rsp_value_a, rsp_value_b;
   logic [1:0]  rsp_status;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   logic        csr_pready;
   int          fail_count, pending;
   int          idle_mode = 0;
   bit          hold_req = 0, hold_done = 0;
   logic [31:0] cur_p = 32'd23;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   elgamal_modexp_engine_core i_dut (.*);

   elgamal_modexp_checker i_checker (.*);

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         rsp_pop <= 1'b0;
         repeat (600) @(posedge clock);
         hold_done <= 1'b1;
      end else begin
         rsp_pop <= !(idle_mode >= 2 && $urandom_range(99) < (idle_mode == 2 ? 56 : 14));
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == emx_pkg::REG_MODULUS) cur_p = val;
   endtask

   task automatic send_item(logic [1:0] op, logic [31:0] m, logic [31:0] k,
                            logic [31:0] c1, logic [31:0] c2);
      bit taken;
      int pct;
      pct = (idle_mode == 1) ? 56 : (idle_mode == 3 ? 14 : 0);
      if ($urandom_range(99) < pct) begin
         req_push <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < pct) @(posedge clock);
      end
      req_push <= 1'b1;
      req_opcode <= op;
      req_message <= m;
      req_nonce <= k;
      req_cipher_first <= c1;
      req_cipher_second <= c2;
      do begin
         @(negedge clock);
         taken = !req_full;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic send_random(bit quick);
      logic [1:0]  op;
      logic [31:0] m, k, c1, c2;
      int          pick;
      pick = $urandom_range(99);
      op = pick < 20 ? emx_pkg::OP_PUBKEY : pick < 55 ? emx_pkg::OP_ENCRYPT :
           pick < 95 ? emx_pkg::OP_DECRYPT : OP_UNUSED;
      m = $urandom;
      k = $urandom;
      c1 = $urandom;
      c2 = $urandom;
      if ($urandom_range(9) < 8 && cur_p != 0) begin
         m = m % cur_p;
         c1 = c1 % cur_p;
         c2 = c2 % cur_p;
         if (cur_p > 3) k = 32'd2 + k % (cur_p - 32'd3);
      end
      if (quick) begin
         op = emx_pkg::OP_ENCRYPT;
         m = cur_p + $urandom_range(7);
      end
      send_item(op, m, k, c1, c2);
   endtask

   task automatic settle;
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings p=23 g=5 x=6
      send_item(emx_pkg::OP_PUBKEY, '0, '0, '0, '0);
      send_item(emx_pkg::OP_ENCRYPT, 32'd0, 32'd2, '0, '0);
      send_item(emx_pkg::OP_ENCRYPT, 32'd22, 32'd22, '0, '0);
      send_item(emx_pkg::OP_ENCRYPT, 32'd23, 32'd5, '0, '0);
      send_item(emx_pkg::OP_ENCRYPT, '1, '1, '0, '0);
      send_item(emx_pkg::OP_ENCRYPT, 32'd7, 32'd0, '0, '0);
      send_item(emx_pkg::OP_ENCRYPT, 32'd7, 32'd1, '0, '0);
      send_item(emx_pkg::OP_ENCRYPT, 32'd7, 32'd23, '0, '0);
      send_item(emx_pkg::OP_ENCRYPT, 32'd7, '1, '0, '0);
      send_item(emx_pkg::OP_DECRYPT, '0, '0, 32'd0, 32'd5);
      send_item(emx_pkg::OP_DECRYPT, '0, '0, '1, '1);
      send_item(emx_pkg::OP_DECRYPT, '0, '0, 32'd10, 32'd0);
      send_item(emx_pkg::OP_DECRYPT, '0, '0, 32'd46, 32'd30);
      send_item(OP_UNUSED, '1, '1, '1, '1);
      settle();

      for (int ph = 1; ph <= 8; ph++) begin
         idle_mode = ph % 4;
         case (ph)
            1: begin
               write_reg(emx_pkg::REG_MODULUS, 32'hFFFF_FFFB);
               write_reg(emx_pkg::REG_GEN, 32'd2);
               write_reg(emx_pkg::REG_KEY, $urandom);
            end
            2: begin
               write_reg(emx_pkg::REG_MODULUS, '1);
               write_reg(emx_pkg::REG_GEN, '1);
               write_reg(emx_pkg::REG_KEY, '1);
            end
            3: write_reg(emx_pkg::REG_MODULUS, 32'd0);
            4: write_reg(emx_pkg::REG_MODULUS, 32'd1);
            5: write_reg(emx_pkg::REG_MODULUS, 32'd2);
            6: begin
               write_reg(emx_pkg::REG_MODULUS, 32'd3);
               write_reg(emx_pkg::REG_GEN, 32'd0);
               write_reg(emx_pkg::REG_KEY, 32'd0);
            end
            7: begin
               write_reg(emx_pkg::REG_MODULUS, 32'd65521);
               write_reg(emx_pkg::REG_GEN, 32'd17);
               write_reg(emx_pkg::REG_KEY, $urandom);
            end
            default: begin
               write_reg(emx_pkg::REG_MODULUS, 32'hFFFF_FFFB);
               write_reg(emx_pkg::REG_GEN, $urandom);
               write_reg(emx_pkg::REG_KEY, $urandom);
            end
         endcase
         if (ph == 7) begin
            idle_mode = 0;
            hold_req = 1;
            for (int i = 0; i < 12; i++) send_random(1);
         end
         for (int i = 0; i < 16; i++) send_random(0);
         settle();
      end

      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
